// ===== hdl/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

  localparam logic [8:0] MAX_SECTORS = 9'd256;
  localparam logic [8:0] MAX_STACKS  = 9'd256;

  localparam int DIV_STEPS = 32;
  localparam int SC_STAGES = 11;
  localparam int TAG_DLY   = 1 + DIV_STEPS + SC_STAGES;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RADIUS       = 2'd0,
    REG_SECTOR_TOTAL = 2'd1,
    REG_STACK_TOTAL  = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] RADIUS_RST       = 16'd256;
  localparam logic [8:0]  SECTOR_TOTAL_RST = 9'd36;
  localparam logic [8:0]  STACK_TOTAL_RST  = 9'd18;

  // pi/2 in units of 2^-32, split for two narrow partial products
  localparam logic [32:0] HALF_PI_Q32 = 33'h1_921F_B544;
  localparam logic [15:0] HPI_HI = HALF_PI_Q32[32:17];
  localparam logic [16:0] HPI_LO = HALF_PI_Q32[16:0];

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // exact floor division of a 30-bit value by a constant: x * m >> s
  localparam int SH_42 = 36;
  localparam int SH_56 = 36;
  localparam int SH_20 = 35;
  localparam int SH_30 = 35;
  localparam int SH_6  = 33;
  localparam int SH_12 = 34;
  localparam logic [30:0] RCP_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [30:0] RCP_56 = 31'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [30:0] RCP_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [30:0] RCP_30 = 31'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [30:0] RCP_6  = 31'(((64'd1 << SH_6) + 64'd5) / 64'd6);
  localparam logic [30:0] RCP_12 = 31'(((64'd1 << SH_12) + 64'd11) / 64'd12);

  typedef struct packed {
    logic       vld;
    logic       err;
    logic [8:0] i;
    logic [8:0] j;
  } uvs_tag_t;

  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
  } uvs_trig_t;

  typedef struct packed {
    logic               vld;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic [16:0]        here;
    logic [16:0]        right;
    logic [16:0]        below;
    logic [16:0]        below_right;
    logic               up;
    logic               low;
    logic               err;
  } uvs_res_t;

  function automatic logic [29:0] div_const(logic [29:0] x, logic [30:0] m, int sh);
    logic [60:0] p;
    p = 61'(x) * 61'(m);
    return 30'(p >> sh);
  endfunction

  function automatic logic [29:0] mul_q30(logic [29:0] x, logic [30:0] t);
    logic [60:0] p;
    p = 61'(x) * 61'(t);
    return p[59:30];
  endfunction

  function automatic logic [15:0] q30_to_q15(logic [30:0] v);
    logic [31:0] t;
    t = (32'(v) + 32'h0000_4000) >> 15;
    return (t > 32'd32767) ? 16'd32767 : t[15:0];
  endfunction

  function automatic logic [14:0] trig_mag(logic signed [15:0] t);
    logic signed [15:0] m;
    m = (t < 0) ? -t : t;
    return m[14:0];
  endfunction

  // Q8.8 x Q1.15 product magnitude rounded to Q8.8, sign applied
  function automatic logic signed [16:0] round_q15(logic [30:0] prod, logic neg);
    logic [31:0] t;
    logic [16:0] p;
    t = (32'(prod) + 32'h0000_4000) >> 15;
    p = t[16:0];
    return neg ? -$signed(p) : $signed(p);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/uvs_phase_div.sv =====
`default_nettype none
module uvs_phase_div (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [8:0]  stack_index,
  input  wire logic [8:0]  sector_index,
  input  wire logic [8:0]  stack_total,
  input  wire logic [8:0]  sector_total,
  output logic [31:0]      ph_stk,
  output logic [31:0]      ph_sec
);
  import uvs_pkg::*;

  // lane 0: stack, lane 1: sector; one quotient bit per stage
  logic [8:0]  rem_r [0:DIV_STEPS][0:1];
  logic [31:0] wrd_r [0:DIV_STEPS][0:1];
  logic [8:0]  dv    [0:1];

  assign dv[0] = stack_total;
  assign dv[1] = sector_total;

  // dividend = i*2^31 + nt/2 and j*2^32 + ns/2; j == ns wraps to zero
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0][0] <= {1'b0, stack_index[8:1]};
      wrd_r[0][0] <= {stack_index[0], 23'd0, stack_total[8:1]};
      rem_r[0][1] <= (sector_index == sector_total) ? 9'd0 : sector_index;
      wrd_r[0][1] <= {24'd0, sector_total[8:1]};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [9:0] r2;
      logic [9:0] diff;
      logic       ge;
      always_comb begin
        r2   = {rem_r[k][l], wrd_r[k][l][31]};
        diff = r2 - {1'b0, dv[l]};
        ge   = (r2 >= {1'b0, dv[l]});
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k+1][l] <= ge ? diff[8:0] : r2[8:0];
          wrd_r[k+1][l] <= {wrd_r[k][l][30:0], ge};
        end
      end
    end
  end

  assign ph_stk = QUARTER_TURN - wrd_r[DIV_STEPS][0];
  assign ph_sec = wrd_r[DIV_STEPS][1];

endmodule
`default_nettype wire

// ===== hdl/uvs_sincos.sv =====
`default_nettype none
module uvs_sincos (
  input  wire logic         clk,
  input  wire logic         adv,
  input  wire logic [31:0]  phase,
  output uvs_pkg::uvs_trig_t trig
);
  import uvs_pkg::*;

  logic [2:0]  oct_r [1:SC_STAGES-1];
  logic [29:0] r1_r;
  logic [45:0] pp_hi_r;
  logic [46:0] pp_lo_r;
  logic [29:0] a_r  [3:9];
  logic [29:0] x2_r [4:9];
  logic [29:0] qs1_r, qc1_r, ms1_r, mc1_r, qs2_r, qc2_r;
  logic [29:0] ms2_r, mc2_r, qs3_r, qc3_r, sv_r, mc3_r;
  uvs_trig_t   trig_r;

  logic [62:0] a_sum;
  logic [59:0] a_sq;
  logic [30:0] cv;
  logic signed [15:0] s0, c0;
  uvs_trig_t   trig_nxt;

  always_comb begin
    a_sum = {pp_hi_r, 17'd0} + 63'(pp_lo_r) + 63'h0000_0000_8000_0000;
    a_sq  = 60'(a_r[3]) * 60'(a_r[3]);
    cv    = ONE_Q30 - 31'(mc3_r >> 1);
    s0    = $signed(q30_to_q15(31'(sv_r)));
    c0    = $signed(q30_to_q15(cv));
    case (oct_r[SC_STAGES-1])
      3'd0:    begin trig_nxt.s = s0;  trig_nxt.c = c0;  end
      3'd1:    begin trig_nxt.s = c0;  trig_nxt.c = s0;  end
      3'd2:    begin trig_nxt.s = c0;  trig_nxt.c = -s0; end
      3'd3:    begin trig_nxt.s = s0;  trig_nxt.c = -c0; end
      3'd4:    begin trig_nxt.s = -s0; trig_nxt.c = -c0; end
      3'd5:    begin trig_nxt.s = -c0; trig_nxt.c = -s0; end
      3'd6:    begin trig_nxt.s = -c0; trig_nxt.c = s0;  end
      default: begin trig_nxt.s = -s0; trig_nxt.c = c0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // octant reduction, mirror odd octants
      oct_r[1] <= phase[31:29];
      r1_r     <= phase[29] ? (30'h2000_0000 - {1'b0, phase[28:0]}) : {1'b0, phase[28:0]};
      for (int k = 2; k < SC_STAGES; k++) oct_r[k] <= oct_r[k-1];
      // angle in Q2.30
      pp_hi_r  <= 46'(r1_r) * 46'(HPI_HI);
      pp_lo_r  <= 47'(r1_r) * 47'(HPI_LO);
      a_r[3]   <= a_sum[61:32];
      for (int k = 4; k <= 9; k++) a_r[k] <= a_r[k-1];
      x2_r[4]  <= a_sq[59:30];
      for (int k = 5; k <= 9; k++) x2_r[k] <= x2_r[k-1];
      // Horner steps, sine and cosine side by side
      qs1_r <= div_const(x2_r[4], RCP_42, SH_42);
      qc1_r <= div_const(x2_r[4], RCP_56, SH_56);
      ms1_r <= mul_q30(x2_r[5], ONE_Q30 - 31'(qs1_r));
      mc1_r <= mul_q30(x2_r[5], ONE_Q30 - 31'(qc1_r));
      qs2_r <= div_const(ms1_r, RCP_20, SH_20);
      qc2_r <= div_const(mc1_r, RCP_30, SH_30);
      ms2_r <= mul_q30(x2_r[7], ONE_Q30 - 31'(qs2_r));
      mc2_r <= mul_q30(x2_r[7], ONE_Q30 - 31'(qc2_r));
      qs3_r <= div_const(ms2_r, RCP_6, SH_6);
      qc3_r <= div_const(mc2_r, RCP_12, SH_12);
      sv_r  <= mul_q30(a_r[9], ONE_Q30 - 31'(qs3_r));
      mc3_r <= mul_q30(x2_r[9], ONE_Q30 - 31'(qc3_r));
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule
`default_nettype wire

// ===== hdl/uvs_geom.sv =====
`default_nettype none
module uvs_geom (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire uvs_pkg::uvs_trig_t trig_stk,
  input  wire uvs_pkg::uvs_trig_t trig_sec,
  input  wire uvs_pkg::uvs_tag_t  tag,
  input  wire logic [15:0]        radius,
  input  wire logic [8:0]         sector_total,
  input  wire logic [8:0]         stack_total,
  output uvs_pkg::uvs_res_t       res
);
  import uvs_pkg::*;

  uvs_tag_t  tag1_r, tag2_r, tag3_r;
  uvs_trig_t sec1_r, sec2_r;
  logic [30:0] pxy_r, pz_r, px_r, py_r;
  logic        nxy_r, nz_r, nx_r, ny_r;
  logic [16:0] here1_r;
  logic signed [16:0] xy_r, z2_r, z3_r;
  logic [16:0] here2_r, right2_r, below2_r, br2_r;
  logic [16:0] here3_r, right3_r, below3_r, br3_r;
  logic        up2_r, low2_r, up3_r, low3_r;
  uvs_res_t    res_r;

  logic [18:0] row_base;
  logic        in_grid, up, low;
  logic [16:0] below;
  logic signed [16:0] xy_mag;

  always_comb begin
    row_base = 19'(tag.i) * 19'({1'b0, sector_total} + 10'd1);
    in_grid  = (tag1_r.i < stack_total) && (tag1_r.j < sector_total);
    up       = in_grid && (tag1_r.i != 9'd0);
    low      = in_grid && (tag1_r.i != stack_total - 9'd1);
    below    = here1_r + 17'(sector_total) + 17'd1;
    xy_mag   = (xy_r < 0) ? -xy_r : xy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.vld <= 1'b0;
      tag2_r.vld <= 1'b0;
      tag3_r.vld <= 1'b0;
      res_r.vld  <= 1'b0;
    end else if (adv) begin
      // radius times stack cosine and sine, vertex index
      tag1_r  <= tag;
      sec1_r  <= trig_sec;
      pxy_r   <= 31'(radius) * 31'(trig_mag(trig_stk.c));
      pz_r    <= 31'(radius) * 31'(trig_mag(trig_stk.s));
      nxy_r   <= trig_stk.c < 0;
      nz_r    <= trig_stk.s < 0;
      here1_r <= 17'(row_base + 19'(tag.j));
      // round, corners
      tag2_r   <= tag1_r;
      sec2_r   <= sec1_r;
      xy_r     <= round_q15(pxy_r, nxy_r);
      z2_r     <= round_q15(pz_r, nz_r);
      here2_r  <= here1_r;
      up2_r    <= up;
      low2_r   <= low;
      right2_r <= (up || low) ? here1_r + 17'd1 : 17'd0;
      below2_r <= (up || low) ? below : 17'd0;
      br2_r    <= (up || low) ? below + 17'd1 : 17'd0;
      // xy times sector cosine and sine
      tag3_r   <= tag2_r;
      px_r     <= 31'(xy_mag[15:0]) * 31'(trig_mag(sec2_r.c));
      py_r     <= 31'(xy_mag[15:0]) * 31'(trig_mag(sec2_r.s));
      nx_r     <= (xy_r < 0) ^ (sec2_r.c < 0);
      ny_r     <= (xy_r < 0) ^ (sec2_r.s < 0);
      z3_r     <= z2_r;
      here3_r  <= here2_r;
      right3_r <= right2_r;
      below3_r <= below2_r;
      br3_r    <= br2_r;
      up3_r    <= up2_r;
      low3_r   <= low2_r;
      // round, zero all fields on a grid error
      res_r.vld         <= tag3_r.vld;
      res_r.err         <= tag3_r.err;
      res_r.pos_x       <= tag3_r.err ? 17'sd0 : round_q15(px_r, nx_r);
      res_r.pos_y       <= tag3_r.err ? 17'sd0 : round_q15(py_r, ny_r);
      res_r.pos_z       <= tag3_r.err ? 17'sd0 : z3_r;
      res_r.here        <= tag3_r.err ? 17'd0 : here3_r;
      res_r.right       <= tag3_r.err ? 17'd0 : right3_r;
      res_r.below       <= tag3_r.err ? 17'd0 : below3_r;
      res_r.below_right <= tag3_r.err ? 17'd0 : br3_r;
      res_r.up          <= up3_r && !tag3_r.err;
      res_r.low         <= low3_r && !tag3_r.err;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== hdl/uv_sphere_vertex_index_generator.sv =====
`default_nettype none
// UV sphere vertex and index generator.
// Input stream: one grid point per transaction, in_tdata = {pad, sector_index,
// stack_index}. Output stream: one transaction per accepted point with the
// vertex position (signed Q8.8) and the four corner vertex indices in out_tdata,
// and the upper-triangle, lower-triangle and grid-error flags in out_tuser.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 radius,
// 1 sector_total, 2 stack_total); write only while no point is in flight.
// Pipeline: a 33-stage phase divider (operand load plus one quotient bit per
// stage), an 11-stage sine/cosine pipeline, a 4-stage scaling and index
// pipeline and the output register.
// Throughput: one point per cycle, sustained while the output does not stall.
// Reset (synchronous, rst_n low): registers return to radius 1.0, 36 sectors,
// 18 stacks, and all in-flight points are dropped.
// Stall: while out_tready is low and a result waits in the output register,
// the pipeline keeps moving until its last stage holds a result; then all
// stages hold and in_tready drops. Nothing is lost or repeated.
module uv_sphere_vertex_index_generator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [uvs_pkg::IN_TDATA_W-1:0]      in_tdata,   // stack_index, sector_index
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // pos_x, pos_y, pos_z, corner_here, corner_right, corner_below, corner_below_right
  output logic [uvs_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // upper_triangle_valid, lower_triangle_valid, grid_error
  output logic [uvs_pkg::OUT_TUSER_W-1:0]          out_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [uvs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [uvs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import uvs_pkg::*;

  logic [15:0] radius_r;
  logic [8:0]  sector_total_r, stack_total_r;
  uvs_tag_t    tag_r [0:TAG_DLY-1];
  uvs_tag_t    tag_nxt;
  logic [31:0] ph_stk, ph_sec;
  uvs_trig_t   trig_stk, trig_sec;
  uvs_res_t    res;
  uvs_res_t    out_r;
  logic        out_vld_r;
  logic        adv;
  logic [8:0]  stack_index, sector_index;

  assign stack_index  = in_tdata[8:0];
  assign sector_index = in_tdata[17:9];

  // advance unless the last stage holds a result the output register cannot take
  assign adv       = !res.vld || !out_vld_r || out_tready;
  assign in_tready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r       <= RADIUS_RST;
      sector_total_r <= SECTOR_TOTAL_RST;
      stack_total_r  <= STACK_TOTAL_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_RADIUS:       radius_r       <= cfg_wdata;
        REG_SECTOR_TOTAL: sector_total_r <= cfg_wdata[8:0];
        REG_STACK_TOTAL:  stack_total_r  <= cfg_wdata[8:0];
        default:          ;
      endcase
    end
  end

  // flag bad totals or indices at entry
  always_comb begin
    tag_nxt.vld = in_tvalid;
    tag_nxt.i   = stack_index;
    tag_nxt.j   = sector_index;
    tag_nxt.err = (sector_total_r == 9'd0) || (sector_total_r > MAX_SECTORS) ||
                  (stack_total_r == 9'd0) || (stack_total_r > MAX_STACKS) ||
                  (stack_index > stack_total_r) || (sector_index > sector_total_r);
  end

  // carry valid, error and indices alongside divider and sine/cosine stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAG_DLY; k++) tag_r[k].vld <= 1'b0;
    end else if (adv) begin
      tag_r[0] <= tag_nxt;
      for (int k = 1; k < TAG_DLY; k++) tag_r[k] <= tag_r[k-1];
    end
  end

  uvs_phase_div u_div (
    .clk          (clk),
    .adv          (adv),
    .stack_index  (stack_index),
    .sector_index (sector_index),
    .stack_total  (stack_total_r),
    .sector_total (sector_total_r),
    .ph_stk       (ph_stk),
    .ph_sec       (ph_sec)
  );

  uvs_sincos u_sc_stk (
    .clk   (clk),
    .adv   (adv),
    .phase (ph_stk),
    .trig  (trig_stk)
  );

  uvs_sincos u_sc_sec (
    .clk   (clk),
    .adv   (adv),
    .phase (ph_sec),
    .trig  (trig_sec)
  );

  uvs_geom u_geom (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .trig_stk     (trig_stk),
    .trig_sec     (trig_sec),
    .tag          (tag_r[TAG_DLY-1]),
    .radius       (radius_r),
    .sector_total (sector_total_r),
    .stack_total  (stack_total_r),
    .res          (res)
  );

  // output register: load a finished result, hold it until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && res.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_r.below_right, out_r.below, out_r.right, out_r.here,
                       out_r.pos_z, out_r.pos_y, out_r.pos_x};
  assign out_tuser  = {out_r.err, out_r.low, out_r.up};

endmodule
`default_nettype wire

// ===== hdl/uvs_checker.sv =====
`default_nettype none
module uvs_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [uvs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic [uvs_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> (out_tdata == '0) && !out_tuser[0] && !out_tuser[1])
    else $error("grid error with nonzero fields");

  a_right_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[1]) |->
      out_tdata[84:68] == out_tdata[67:51] + 17'd1)
    else $error("right corner is not next vertex");

  a_no_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && !out_tuser[1] |-> out_tdata[118:68] == '0)
    else $error("corners set without a triangle");

endmodule

bind uv_sphere_vertex_index_generator uvs_checker u_uvs_checker (.*);
`default_nettype wire

// ===== test/tb_uv_sphere_vertex_index_generator.sv =====
`timescale 1ns / 100ps
module tb_uv_sphere_vertex_index_generator;
  import uvs_pkg::*;

  // One result transaction, unpacked from out_tdata and out_tuser
  typedef struct {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [16:0] here;
    logic [16:0] right;
    logic [16:0] below;
    logic [16:0] below_right;
    logic        up;
    logic        low;
    logic        err;
  } vertex_t;

  // Directed grid point; typed rows carry a hand-derived expectation
  typedef struct {
    logic [8:0] stack_i;
    logic [8:0] sector_j;
    bit         typed;
    vertex_t    vtx;
  } grid_row_t;

  localparam int LATENCY_WAIT = 60;
  localparam int ROWS         = 12;
  localparam int PHASES       = 10;
  localparam int PER_PHASE    = 118;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // stack_index, sector_index
  logic                   out_tvalid;
  logic                   out_tready;
  // pos_x, pos_y, pos_z, corner_here, corner_right, corner_below, corner_below_right
  logic [OUT_TDATA_W-1:0] out_tdata;
  // upper_triangle_valid, lower_triangle_valid, grid_error
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // Shadow copy of the register file
  longint unsigned radius_q88;
  longint unsigned sector_cnt;
  longint unsigned stack_cnt;

  vertex_t   vertex_fifo[$];
  int        mismatches;
  int        points_sent;
  int        results_seen;
  bit        calm_sender;
  bit        calm_receiver;
  int        hold_cycles;
  grid_row_t rows[ROWS];

  uv_sphere_vertex_index_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Q2.30 magnitude to Q1.15, round half up, saturate
  function automatic int q30_round(longint unsigned v);
    longint unsigned q;
    q = (v + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return int'(q);
  endfunction

  function automatic longint unsigned frac_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Sine and cosine of a 32-bit phase: fold into the first octant, then Taylor series
  function automatic void phase_trig(input logic [31:0] ph, output int s, output int c);
    longint unsigned r, a, x2, t, sv, cv;
    int s0, c0;
    logic [2:0] oct;
    oct = ph[31:29];
    r = 64'(ph[28:0]);
    if (oct[0]) r = (64'd1 << 29) - r;
    a = (r * 64'(HALF_PI_Q32) + (64'd1 << 31)) >> 32;
    x2 = frac_mul(a, a);
    t = (64'd1 << 30) - x2 / 42;
    t = (64'd1 << 30) - frac_mul(x2, t) / 20;
    t = (64'd1 << 30) - frac_mul(x2, t) / 6;
    sv = frac_mul(a, t);
    t = (64'd1 << 30) - x2 / 56;
    t = (64'd1 << 30) - frac_mul(x2, t) / 30;
    t = (64'd1 << 30) - frac_mul(x2, t) / 12;
    cv = (64'd1 << 30) - frac_mul(x2, t) / 2;
    s0 = q30_round(sv);
    c0 = q30_round(cv);
    case (oct)
      3'd0: begin s = s0;  c = c0;  end
      3'd1: begin s = c0;  c = s0;  end
      3'd2: begin s = c0;  c = -s0; end
      3'd3: begin s = s0;  c = -c0; end
      3'd4: begin s = -s0; c = -c0; end
      3'd5: begin s = -c0; c = -s0; end
      3'd6: begin s = -c0; c = s0;  end
      default: begin s = -s0; c = c0; end
    endcase
  endfunction

  // Q8.8 times Q1.15 back to Q8.8, ties away from zero
  function automatic longint scale_q88(longint v, int tr);
    bit neg;
    longint unsigned mv, mt, p;
    neg = v < 0;
    mv = (v < 0) ? -v : v;
    if (tr < 0) neg = !neg;
    mt = (tr < 0) ? -longint'(tr) : longint'(tr);
    p = (mv * mt + 64'd16384) >> 15;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic vertex_t predict_vertex(logic [8:0] si, logic [8:0] sj);
    vertex_t v;
    longint unsigned i, j, ns, nt, here;
    logic [31:0] ph_sec, ph_stk;
    int ss, cs, sa, ca;
    longint xy, x, y, z;
    bit up, low;
    i = si;
    j = sj;
    ns = sector_cnt;
    nt = stack_cnt;
    v = '{default: '0};
    if (ns == 0 || ns > 256 || nt == 0 || nt > 256 || i > nt || j > ns) begin
      v.err = 1'b1;
      return v;
    end
    ph_sec = 32'(((j << 32) + ns / 2) / ns);
    ph_stk = 32'((64'd1 << 30) - ((i << 31) + nt / 2) / nt);
    phase_trig(ph_stk, ss, cs);
    phase_trig(ph_sec, sa, ca);
    xy = scale_q88(longint'(radius_q88), cs);
    z = scale_q88(longint'(radius_q88), ss);
    x = scale_q88(xy, ca);
    y = scale_q88(xy, sa);
    here = i * (ns + 1) + j;
    up = (i < nt) && (j < ns) && (i != 0);
    low = (i < nt) && (j < ns) && (i != nt - 1);
    v.pos_x = 17'(x);
    v.pos_y = 17'(y);
    v.pos_z = 17'(z);
    v.here = 17'(here);
    v.up = up;
    v.low = low;
    if (up || low) begin
      v.right = 17'(here + 1);
      v.below = 17'(here + ns + 1);
      v.below_right = 17'(here + ns + 2);
    end
    return v;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RADIUS:       radius_q88 = val;
      REG_SECTOR_TOTAL: sector_cnt = val[8:0];
      default:          stack_cnt = val[8:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one grid point, with random gaps, until it is accepted
  task automatic send_point(logic [8:0] si, logic [8:0] sj, bit typed, vertex_t tv);
    vertex_t exp_v;
    @(negedge clk);
    while (!calm_sender && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, sj, si};
    do @(posedge clk); while (!in_tready);
    exp_v = typed ? tv : predict_vertex(si, sj);
    vertex_fifo.insert(vertex_fifo.size(), exp_v);
    points_sent++;
    calm_sender = (points_sent >= 500 && points_sent < 700);
  endtask

  // Hold off before a register write until the pipeline has drained
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (vertex_fifo.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [16:0] exp_v, logic [16:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Receiver: random stalls, one long hold-off to back the pipeline up, a calm stretch
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (results_seen == 300 && !out_tready) begin
      out_tready <= 1'b1;
    end else if (results_seen == 250 && out_tready) begin
      hold_cycles <= 200;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm_receiver || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    vertex_t act, exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      act.pos_x = out_tdata[16:0];
      act.pos_y = out_tdata[33:17];
      act.pos_z = out_tdata[50:34];
      act.here = out_tdata[67:51];
      act.right = out_tdata[84:68];
      act.below = out_tdata[101:85];
      act.below_right = out_tdata[118:102];
      act.up = out_tuser[0];
      act.low = out_tuser[1];
      act.err = out_tuser[2];
      if (vertex_fifo.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatches++;
      end else begin
        exp_v = vertex_fifo.pop_front();
        check_field("pos_x", exp_v.pos_x, act.pos_x);
        check_field("pos_y", exp_v.pos_y, act.pos_y);
        check_field("pos_z", exp_v.pos_z, act.pos_z);
        check_field("corner_here", exp_v.here, act.here);
        check_field("corner_right", exp_v.right, act.right);
        check_field("corner_below", exp_v.below, act.below);
        check_field("corner_below_right", exp_v.below_right, act.below_right);
        check_field("upper_triangle_valid", 17'(exp_v.up), 17'(act.up));
        check_field("lower_triangle_valid", 17'(exp_v.low), 17'(act.low));
        check_field("grid_error", 17'(exp_v.err), 17'(act.err));
      end
      results_seen++;
      calm_receiver <= (results_seen >= 550 && results_seen < 750);
    end
  end

  // Generous limit on the whole run
  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    // radius, sectors, stacks per phase; extremes and bad totals included
    int unsigned settings[PHASES][3];
    vertex_t none_v, err_v, pole_v;
    int unsigned lim_i, lim_j;
    logic [8:0] si, sj;

    settings = '{
      '{256, 36, 18}, '{65535, 256, 256}, '{0, 1, 1}, '{65535, 1, 256},
      '{12345, 7, 3}, '{600, 256, 1}, '{1000, 0, 5}, '{800, 10, 300},
      '{32768, 511, 2}, '{40000, 100, 100}};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_RADIUS;
    cfg_wdata = '0;
    mismatches = 0;
    points_sent = 0;
    results_seen = 0;
    calm_sender = 0;
    calm_receiver = 0;
    hold_cycles = 0;
    radius_q88 = RADIUS_RST;
    sector_cnt = SECTOR_TOTAL_RST;
    stack_cnt = STACK_TOTAL_RST;

    none_v = '{default: '0};
    err_v = none_v;
    err_v.err = 1'b1;
    // Top pole of the reset sphere: unit z, lower triangle only
    pole_v = none_v;
    pole_v.pos_z = 17'd256;
    pole_v.low = 1'b1;
    pole_v.right = 17'd1;
    pole_v.below = 17'd37;
    pole_v.below_right = 17'd38;

    rows = '{
      '{9'd0,   9'd0,   1, pole_v},
      '{9'd19,  9'd0,   1, err_v},   // row above stack count
      '{9'd0,   9'd37,  1, err_v},   // column above sector count
      '{9'd511, 9'd511, 1, err_v},
      '{9'd18,  9'd0,   0, none_v},  // bottom pole, no triangles
      '{9'd18,  9'd36,  0, none_v},
      '{9'd0,   9'd36,  0, none_v},  // seam column, no triangles
      '{9'd17,  9'd5,   0, none_v},  // last row, upper triangle only
      '{9'd9,   9'd18,  0, none_v},
      '{9'd5,   9'd35,  0, none_v},
      '{9'd1,   9'd9,   0, none_v},
      '{9'd12,  9'd27,  0, none_v}};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) send_point(rows[k].stack_i, rows[k].sector_j, rows[k].typed, rows[k].vtx);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_RADIUS, 16'(settings[p][0]));
      write_reg(REG_SECTOR_TOTAL, 16'(settings[p][1]));
      write_reg(REG_STACK_TOTAL, 16'(settings[p][2]));
      lim_i = (stack_cnt == 0) ? 1 : stack_cnt;
      lim_j = (sector_cnt == 0) ? 1 : sector_cnt;
      for (int n = 0; n < PER_PHASE; n++) begin
        // mostly points on the grid, edges favored, some out of range
        if ($urandom_range(99) < 85) begin
          si = 9'($urandom_range(lim_i, 0));
          sj = 9'($urandom_range(lim_j, 0));
          if ($urandom_range(9) == 0) si = 9'(lim_i);
          if ($urandom_range(9) == 0) sj = 9'(lim_j);
        end else begin
          si = 9'($urandom_range(511, 0));
          sj = 9'($urandom_range(511, 0));
        end
        send_point(si, sj, 0, none_v);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (vertex_fifo.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/uvs_pkg.sv
hdl/uvs_phase_div.sv
hdl/uvs_sincos.sv
hdl/uvs_geom.sv
hdl/uv_sphere_vertex_index_generator.sv
hdl/uvs_checker.sv
test/tb_uv_sphere_vertex_index_generator.sv
